// ----- sv/rot90_pkg.sv -----
package rot90_pkg;

  localparam int unsigned MAX_DIM      = 64;
  localparam int unsigned CHANNEL_BITS = 8;

  localparam int unsigned STORE_DEPTH = MAX_DIM * MAX_DIM;
  localparam int unsigned ADDR_W      = $clog2(STORE_DEPTH);
  localparam int unsigned CNT_W       = $clog2(STORE_DEPTH + 1);
  localparam int unsigned DIM_W       = $clog2(MAX_DIM + 1);
  localparam int unsigned POS_W       = $clog2(MAX_DIM);
  localparam int unsigned PIX_W       = 3 * CHANNEL_BITS;
  localparam int unsigned CFG_IDX_W   = 1;
  localparam int unsigned QUEUE_DEPTH = 2;

  // request codes
  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_FETCH = 1'b1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = CFG_IDX_W'(1);

  typedef enum logic [1:0] {
    OP_LOAD,
    OP_FETCH,
    OP_ERR
  } op_e;

  // one classified request, front to back
  typedef struct packed {
    op_e               op;
    logic [ADDR_W-1:0] addr;
    logic [PIX_W-1:0]  pix;
    logic [POS_W-1:0]  row;
    logic [POS_W-1:0]  col;
    logic              last;
  } cmd_t;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
    logic [DIM_W-1:0] r;
    begin
      if (v == '0) begin
        r = DIM_W'(1);
      end else if (v > DIM_W'(MAX_DIM)) begin
        r = DIM_W'(MAX_DIM);
      end else begin
        r = v;
      end
      return r;
    end
  endfunction

endpackage

// ----- sv/image_rotate_ccw_90_core.sv -----
// Channel   Direction  Handshake                 Payload
// request   in         start_i / busy_o          req_type_i, in_red_i, in_green_i, in_blue_i
// result    out        done_o (one-cycle strobe) status_o, out_red_o/green/blue, out_row_o,
//                                                out_col_o, last_pixel_o
// config    in         cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//
// A request transfers when start_i is high and busy_o is low. Its result comes
// on done_o after the command queue and the back-end result register; one request
// per cycle is sustained, bounded by the single frame-store port used once per request.
// Reset clears counters, dimensions (64x64) and the queue; the frame store is not cleared.
// The receiver cannot stall; busy_o rises only if the two-entry command queue fills.
module image_rotate_ccw_90_core (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // request channel
  input  logic                            start_i,
  output logic                            busy_o,
  input  logic                            req_type_i,
  input  logic [rot90_pkg::CHANNEL_BITS-1:0] in_red_i,
  input  logic [rot90_pkg::CHANNEL_BITS-1:0] in_green_i,
  input  logic [rot90_pkg::CHANNEL_BITS-1:0] in_blue_i,
  // result channel
  output logic                            done_o,
  output logic                            status_o,
  output logic [rot90_pkg::CHANNEL_BITS-1:0] out_red_o,
  output logic [rot90_pkg::CHANNEL_BITS-1:0] out_green_o,
  output logic [rot90_pkg::CHANNEL_BITS-1:0] out_blue_o,
  output logic [rot90_pkg::POS_W-1:0]     out_row_o,
  output logic [rot90_pkg::POS_W-1:0]     out_col_o,
  output logic                            last_pixel_o,
  // configuration channel
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [rot90_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [rot90_pkg::DIM_W-1:0]     cfg_data_i
);
  import rot90_pkg::*;

  logic             accept;
  logic             push;
  cmd_t             push_cmd;
  cmd_t             head_cmd;
  logic             q_empty;
  logic             q_full;
  logic             pop;
  logic [PIX_W-1:0] res_pix;

  // registers are always writable; writes must land only while idle, which the block itself does not enforce
  assign cfg_ready_o = 1'b1;

  assign busy_o = q_full;
  assign accept = start_i && !q_full;

  // front: classify request, track load count and rotated scan position
  rot90_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .req_type_i  (req_type_i),
    .pix_i       ({in_red_i, in_green_i, in_blue_i}),
    .cfg_we_i    (cfg_valid_i && cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .push_o      (push),
    .cmd_o       (push_cmd)
  );

  rot90_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (push_cmd),
    .pop_i   (pop),
    .cmd_o   (head_cmd),
    .empty_o (q_empty),
    .full_o  (q_full)
  );

  // back: frame-store write or read, then the result strobe
  rot90_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .empty_i  (q_empty),
    .cmd_i    (head_cmd),
    .pop_o    (pop),
    .done_o   (done_o),
    .status_o (status_o),
    .pix_o    (res_pix),
    .row_o    (out_row_o),
    .col_o    (out_col_o),
    .last_o   (last_pixel_o)
  );

  assign out_red_o   = res_pix[3*CHANNEL_BITS-1:2*CHANNEL_BITS];
  assign out_green_o = res_pix[2*CHANNEL_BITS-1:CHANNEL_BITS];
  assign out_blue_o  = res_pix[CHANNEL_BITS-1:0];

endmodule

// ----- sv/rot90_ram.sv -----
module rot90_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- sv/rot90_front.sv -----
module rot90_front (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            accept_i,
  input  logic                            req_type_i,
  input  logic [rot90_pkg::PIX_W-1:0]     pix_i,
  input  logic                            cfg_we_i,
  input  logic [rot90_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [rot90_pkg::DIM_W-1:0]     cfg_data_i,
  output logic                            push_o,
  output rot90_pkg::cmd_t                 cmd_o
);
  import rot90_pkg::*;

  logic [DIM_W-1:0]  width_q, width_d;
  logic [DIM_W-1:0]  height_q, height_d;
  logic [CNT_W-1:0]  total_q, total_d;
  logic [CNT_W-1:0]  load_cnt_q, load_cnt_d;
  logic [POS_W-1:0]  row_q, row_d;
  logic [POS_W-1:0]  col_q, col_d;
  logic [POS_W-1:0]  base_q, base_d;   // width-1-row: address of column 0 in this row
  logic [ADDR_W-1:0] faddr_q, faddr_d;
  logic              is_full;
  logic              is_last;
  logic [DIM_W-1:0]  new_dim;
  logic [2*DIM_W-1:0] prod;

  assign is_full = (load_cnt_q == total_q);
  assign is_last = ({1'b0, row_q} == width_q - DIM_W'(1))
                && ({1'b0, col_q} == height_q - DIM_W'(1));
  assign new_dim = clamp_dim(cfg_data_i);

  always_comb begin
    width_d    = width_q;
    height_d   = height_q;
    prod       = {width_q, height_q} & '0;
    total_d    = total_q;
    load_cnt_d = load_cnt_q;
    row_d      = row_q;
    col_d      = col_q;
    base_d     = base_q;
    faddr_d    = faddr_q;
    push_o     = 1'b0;
    cmd_o      = '0;
    cmd_o.op   = OP_ERR;

    if (cfg_we_i) begin
      if (cfg_index_i == REG_WIDTH) begin
        width_d = new_dim;
      end else begin
        height_d = new_dim;
      end
      prod       = width_d * height_d;
      total_d    = prod[CNT_W-1:0];
      // a register write drops the image in progress
      load_cnt_d = '0;
      row_d      = '0;
      col_d      = '0;
      base_d     = POS_W'(width_d - DIM_W'(1));
      faddr_d    = ADDR_W'(width_d - DIM_W'(1));
    end else if (accept_i) begin
      push_o = 1'b1;
      if (req_type_i == REQ_LOAD) begin
        if (!is_full) begin
          cmd_o.op   = OP_LOAD;
          cmd_o.addr = load_cnt_q[ADDR_W-1:0];
          cmd_o.pix  = pix_i;
          load_cnt_d = load_cnt_q + CNT_W'(1);
        end
      end else if (is_full) begin
        cmd_o.op   = OP_FETCH;
        cmd_o.addr = faddr_q;
        cmd_o.row  = row_q;
        cmd_o.col  = col_q;
        cmd_o.last = is_last;
        if (is_last) begin
          load_cnt_d = '0;
          row_d      = '0;
          col_d      = '0;
          base_d     = POS_W'(width_q - DIM_W'(1));
          faddr_d    = ADDR_W'(width_q - DIM_W'(1));
        end else if ({1'b0, col_q} == height_q - DIM_W'(1)) begin
          col_d   = '0;
          row_d   = row_q + POS_W'(1);
          base_d  = base_q - POS_W'(1);
          faddr_d = ADDR_W'(base_q - POS_W'(1));
        end else begin
          col_d   = col_q + POS_W'(1);
          faddr_d = faddr_q + ADDR_W'(width_q);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q    <= DIM_W'(MAX_DIM);
      height_q   <= DIM_W'(MAX_DIM);
      total_q    <= CNT_W'(STORE_DEPTH);
      load_cnt_q <= '0;
      row_q      <= '0;
      col_q      <= '0;
      base_q     <= POS_W'(MAX_DIM - 1);
      faddr_q    <= ADDR_W'(MAX_DIM - 1);
    end else begin
      width_q    <= width_d;
      height_q   <= height_d;
      total_q    <= total_d;
      load_cnt_q <= load_cnt_d;
      row_q      <= row_d;
      col_q      <= col_d;
      base_q     <= base_d;
      faddr_q    <= faddr_d;
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_cnt_q <= total_q)
    else $error("load count past image size");

  a_fetch_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o && cmd_o.op == OP_FETCH |-> is_full)
    else $error("fetch issued before image complete");

  a_fetch_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    is_full |-> {1'b0, faddr_q} < total_q)
    else $error("fetch address outside image");

endmodule

// ----- sv/rot90_queue.sv -----
module rot90_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  rot90_pkg::cmd_t cmd_i,
  input  logic            pop_i,
  output rot90_pkg::cmd_t cmd_o,
  output logic            empty_o,
  output logic            full_o
);
  import rot90_pkg::*;

  localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_QW = $clog2(QUEUE_DEPTH + 1);

  cmd_t               slot_q [QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CNT_QW-1:0]  cnt_q, cnt_d;

  assign empty_o = (cnt_q == '0);
  assign full_o  = (cnt_q == CNT_QW'(QUEUE_DEPTH));
  assign cmd_o   = slot_q[rd_ptr_q];

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + CNT_QW'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - CNT_QW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
      end
      cnt_q <= cnt_d;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o |-> !push_i || pop_i)
    else $error("queue overflow");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o)
    else $error("queue underflow");

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_QW'(QUEUE_DEPTH))
    else $error("queue count out of range");

endmodule

// ----- sv/rot90_back.sv -----
module rot90_back (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             empty_i,
  input  rot90_pkg::cmd_t                  cmd_i,
  output logic                             pop_o,
  output logic                             done_o,
  output logic                             status_o,
  output logic [rot90_pkg::PIX_W-1:0]      pix_o,
  output logic [rot90_pkg::POS_W-1:0]      row_o,
  output logic [rot90_pkg::POS_W-1:0]      col_o,
  output logic                             last_o
);
  import rot90_pkg::*;

  logic             vld_q;
  op_e              op_q;
  logic [POS_W-1:0] row_q, col_q;
  logic             last_q;
  logic [PIX_W-1:0] rdata;

  // the result side never stalls, so one command leaves every cycle while the queue holds one
  assign pop_o = !empty_i;

  rot90_ram #(
    .WIDTH (PIX_W),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (pop_o && cmd_i.op == OP_LOAD),
    .addr_i  (cmd_i.addr),
    .wdata_i (cmd_i.pix),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i) begin
    op_q   <= cmd_i.op;
    row_q  <= cmd_i.row;
    col_q  <= cmd_i.col;
    last_q <= cmd_i.last;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= pop_o;
    end
  end

  assign done_o   = vld_q;
  assign status_o = (op_q == OP_ERR);
  assign pix_o    = (op_q == OP_FETCH) ? rdata : '0;
  assign row_o    = row_q;
  assign col_o    = col_q;
  assign last_o   = last_q;

endmodule

// ----- tb/rotation_checker.sv -----
// Watches the request, config and result channels of the rotate core,
// predicts every result and compares it against the DUT output.
module rotation_checker (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  input  logic                               busy_i,
  input  logic                               req_type_i,
  input  logic [rot90_pkg::CHANNEL_BITS-1:0] in_red_i,
  input  logic [rot90_pkg::CHANNEL_BITS-1:0] in_green_i,
  input  logic [rot90_pkg::CHANNEL_BITS-1:0] in_blue_i,
  input  logic                               done_i,
  input  logic                               status_i,
  input  logic [rot90_pkg::CHANNEL_BITS-1:0] out_red_i,
  input  logic [rot90_pkg::CHANNEL_BITS-1:0] out_green_i,
  input  logic [rot90_pkg::CHANNEL_BITS-1:0] out_blue_i,
  input  logic [rot90_pkg::POS_W-1:0]        out_row_i,
  input  logic [rot90_pkg::POS_W-1:0]        out_col_i,
  input  logic                               last_pixel_i,
  input  logic                               cfg_valid_i,
  input  logic                               cfg_ready_i,
  input  logic [rot90_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [rot90_pkg::DIM_W-1:0]        cfg_data_i,
  output int                                 mismatches_o,
  output int                                 pending_o,
  output int                                 frames_o,
  output int                                 rejects_o
);
  import rot90_pkg::*;

  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_ERR = 1'b1;

  typedef struct packed {
    logic                    status;
    logic [CHANNEL_BITS-1:0] red;
    logic [CHANNEL_BITS-1:0] green;
    logic [CHANNEL_BITS-1:0] blue;
    logic [POS_W-1:0]        row;
    logic [POS_W-1:0]        col;
    logic                    last;
  } pixel_result_t;

  logic [PIX_W-1:0] frame_mem [STORE_DEPTH];
  int unsigned      img_w, img_h, loaded, emit_r, emit_c;
  pixel_result_t    expected_pixels [$];
  pixel_result_t    want, got;
  int               mismatches, frames, rejects;

  assign mismatches_o = mismatches;
  assign frames_o     = frames;
  assign rejects_o    = rejects;

  function automatic int unsigned legal_dim(input logic [DIM_W-1:0] raw);
    if (raw == '0) return 1;
    if (raw > MAX_DIM) return MAX_DIM;
    return 32'(raw);
  endfunction

  // One request in, one expected result queued; updates the frame state.
  function automatic void apply_request(input logic kind, input logic [PIX_W-1:0] pix);
    pixel_result_t res;
    int unsigned   area;
    int unsigned   addr;
    res        = '0;
    res.status = STATUS_OK;
    area       = img_w * img_h;
    if (kind == REQ_LOAD) begin
      if (loaded >= area) begin
        res.status = STATUS_ERR;
      end else begin
        frame_mem[loaded] = pix;
        loaded++;
      end
    end else if (loaded < area) begin
      res.status = STATUS_ERR;
    end else begin
      // rotated (r,c) comes from source row c, column w-1-r
      addr = emit_c * img_w + (img_w - 1 - emit_r);
      {res.red, res.green, res.blue} = frame_mem[addr];
      res.row  = emit_r[POS_W-1:0];
      res.col  = emit_c[POS_W-1:0];
      res.last = (emit_r == img_w - 1) && (emit_c == img_h - 1);
      if (res.last) begin
        loaded = 0;
        emit_r = 0;
        emit_c = 0;
        frames++;
      end else if (emit_c == img_h - 1) begin
        emit_c = 0;
        emit_r++;
      end else begin
        emit_c++;
      end
    end
    if (res.status == STATUS_ERR) rejects++;
    expected_pixels.push_back(res);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      img_w      = MAX_DIM;
      img_h      = MAX_DIM;
      loaded     = 0;
      emit_r     = 0;
      emit_c     = 0;
      mismatches = 0;
      frames     = 0;
      rejects    = 0;
      expected_pixels.delete();
      pending_o <= 0;
    end else begin
      // results first: a result seen at this edge predates any request taken here
      if (done_i) begin
        got = {status_i, out_red_i, out_green_i, out_blue_i, out_row_i, out_col_i,
               last_pixel_i};
        if (expected_pixels.size() == 0) begin
          mismatches++;
          $display("%0t: result with none expected: status=%0d rgb=%h row=%0d col=%0d last=%0d",
                   $time, got.status, {got.red, got.green, got.blue}, got.row, got.col,
                   got.last);
        end else begin
          want = expected_pixels.pop_front();
          if (got !== want) begin
            mismatches++;
            $display("%0t: mismatch expected status=%0d rgb=%h row=%0d col=%0d last=%0d",
                     $time, want.status, {want.red, want.green, want.blue}, want.row,
                     want.col, want.last);
            $display("%0t:          actual status=%0d rgb=%h row=%0d col=%0d last=%0d",
                     $time, got.status, {got.red, got.green, got.blue}, got.row, got.col,
                     got.last);
          end
        end
      end
      // any register write drops the image in progress
      if (cfg_valid_i && cfg_ready_i) begin
        if (cfg_index_i == REG_WIDTH) begin
          img_w = legal_dim(cfg_data_i);
        end else if (cfg_index_i == REG_HEIGHT) begin
          img_h = legal_dim(cfg_data_i);
        end
        loaded = 0;
        emit_r = 0;
        emit_c = 0;
      end
      if (start_i && !busy_i) begin
        apply_request(req_type_i, {in_red_i, in_green_i, in_blue_i});
      end
      pending_o <= expected_pixels.size();
    end
  end

endmodule

// ----- tb/image_rotate_ccw_90_core_test.sv -----
// Top of the rotate-core bench: clock, reset, request/config stimulus,
// watchdog and verdict. All prediction and comparison lives in the checker.
module image_rotate_ccw_90_core_test;
  import rot90_pkg::*;

  localparam int unsigned ITEM_TARGET  = 1850;
  // worst legal quiet stretch is a long gap plus settling; keep wide margin
  localparam int unsigned STALL_LIMIT  = 4000;
  // settling margin after the last result, before touching config
  localparam int unsigned SETTLE_CYCLES = 6;
  localparam int unsigned DIM_RAW_MAX  = (1 << DIM_W) - 1;

  logic                    clk        = 1'b0;
  logic                    rst_n      = 1'b0;
  logic                    start      = 1'b0;
  logic                    busy;
  logic                    req_type   = REQ_LOAD;
  logic [CHANNEL_BITS-1:0] in_red     = '0;
  logic [CHANNEL_BITS-1:0] in_green   = '0;
  logic [CHANNEL_BITS-1:0] in_blue    = '0;
  logic                    done;
  logic                    status;
  logic [CHANNEL_BITS-1:0] out_red, out_green, out_blue;
  logic [POS_W-1:0]        out_row, out_col;
  logic                    last_pixel;
  logic                    cfg_valid  = 1'b0;
  logic                    cfg_ready;
  logic [CFG_IDX_W-1:0]    cfg_index  = REG_WIDTH;
  logic [DIM_W-1:0]        cfg_data   = '0;

  int mismatches, pending, frames, rejects;
  int n_items   = 0;
  int n_configs = 0;
  bit burst     = 1'b0;   // no gaps between requests while set

  always #1 clk = ~clk;

  image_rotate_ccw_90_core i_dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .start_i      (start),
    .busy_o       (busy),
    .req_type_i   (req_type),
    .in_red_i     (in_red),
    .in_green_i   (in_green),
    .in_blue_i    (in_blue),
    .done_o       (done),
    .status_o     (status),
    .out_red_o    (out_red),
    .out_green_o  (out_green),
    .out_blue_o   (out_blue),
    .out_row_o    (out_row),
    .out_col_o    (out_col),
    .last_pixel_o (last_pixel),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_o  (cfg_ready),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data)
  );

  rotation_checker i_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .start_i      (start),
    .busy_i       (busy),
    .req_type_i   (req_type),
    .in_red_i     (in_red),
    .in_green_i   (in_green),
    .in_blue_i    (in_blue),
    .done_i       (done),
    .status_i     (status),
    .out_red_i    (out_red),
    .out_green_i  (out_green),
    .out_blue_i   (out_blue),
    .out_row_i    (out_row),
    .out_col_i    (out_col),
    .last_pixel_i (last_pixel),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_i  (cfg_ready),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data),
    .mismatches_o (mismatches),
    .pending_o    (pending),
    .frames_o     (frames),
    .rejects_o    (rejects)
  );

  // One request transfer. Start stays high afterwards unless a gap is drawn,
  // so back-to-back requests never drop and re-raise start in one step.
  task automatic issue_req(input logic kind, input logic [CHANNEL_BITS-1:0] r,
                           input logic [CHANNEL_BITS-1:0] g,
                           input logic [CHANNEL_BITS-1:0] b);
    int unsigned gap;
    int unsigned sel;
    start    <= 1'b1;
    req_type <= kind;
    in_red   <= r;
    in_green <= g;
    in_blue  <= b;
    @(posedge clk);
    while (busy) @(posedge clk);
    n_items++;
    // mostly back-to-back, some short gaps, a few long ones
    sel = $urandom_range(0, 19);
    if (burst || sel < 13) gap = 0;
    else if (sel < 19) gap = $urandom_range(1, 3);
    else gap = $urandom_range(10, 40);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Hold off requests until the checker has nothing outstanding, then settle.
  // pending is registered in the checker, so sample it after an edge.
  task automatic wait_results_done();
    start <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Register write; valid drops before the next write, so consecutive writes never collide.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DIM_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    n_configs++;
    @(posedge clk);
  endtask

  // Raw register value: mostly small images, some large, a few out of range.
  function automatic int unsigned pick_dim();
    int unsigned sel;
    sel = $urandom_range(0, 19);
    if (sel == 0) return 0;
    if (sel == 1) return $urandom_range(MAX_DIM + 1, DIM_RAW_MAX);
    if (sel < 4) return $urandom_range(9, MAX_DIM);
    return $urandom_range(1, 8);
  endfunction

  // Watchdog: ends the run if no transfer of any kind happens for too long.
  initial begin
    int unsigned quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((start && !busy) || done || (cfg_valid && cfg_ready)) quiet = 0;
      else quiet++;
    end
    $display("%0t: watchdog expired after %0d idle cycles", $time, STALL_LIMIT);
    $display("simulation failed");
    $finish;
  end

  initial begin
    int unsigned w_raw, h_raw, w_eff, h_eff, area;
    int unsigned loaded, fetched, n_sent, cut_at, images;
    bit          dropped, noise;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // ---- directed part ----
    // Reset dims are 64x64: fetch on an empty store is rejected, then a lone
    // load that the following register write throws away.
    issue_req(REQ_FETCH, 8'h00, 8'h00, 8'h00);
    issue_req(REQ_LOAD, 8'hA5, 8'h5A, 8'h3C);
    wait_results_done();
    write_reg(REG_WIDTH, DIM_W'(2));
    write_reg(REG_HEIGHT, DIM_W'(3));

    // 2x3 image with channel extremes; fetch before full, load when full
    issue_req(REQ_LOAD, 8'h00, 8'h00, 8'h00);
    issue_req(REQ_LOAD, 8'hFF, 8'hFF, 8'hFF);
    issue_req(REQ_LOAD, 8'hFF, 8'h00, 8'h00);
    issue_req(REQ_LOAD, 8'h00, 8'hFF, 8'h00);
    issue_req(REQ_LOAD, 8'h00, 8'h00, 8'hFF);
    issue_req(REQ_FETCH, 8'hFF, 8'hFF, 8'hFF);
    issue_req(REQ_LOAD, 8'h5A, 8'hA5, 8'hC3);
    issue_req(REQ_LOAD, 8'h12, 8'h34, 8'h56);
    repeat (6) issue_req(REQ_FETCH, 8'h00, 8'h00, 8'h00);
    // store is empty again after the last pixel
    issue_req(REQ_FETCH, 8'h00, 8'h00, 8'h00);

    // smallest image, registers written in the other order
    wait_results_done();
    write_reg(REG_HEIGHT, DIM_W'(1));
    write_reg(REG_WIDTH, DIM_W'(1));
    issue_req(REQ_LOAD, 8'h7F, 8'h80, 8'h01);
    issue_req(REQ_LOAD, 8'h80, 8'h7F, 8'hFE);
    issue_req(REQ_FETCH, 8'h00, 8'h00, 8'h00);

    // ---- random part ----
    // Each phase: idle, program dims, then one or two well-formed frames with
    // a sprinkle of rejected requests; now and then a frame is cut short and
    // the next register write drops it.
    for (int phase = 0; n_items < ITEM_TARGET; phase++) begin
      case (phase)
        0: begin
          w_raw = DIM_RAW_MAX;   // clamps to the widest image, one row
          h_raw = 0;
        end
        1: begin
          w_raw = 0;
          h_raw = DIM_RAW_MAX;
        end
        2: begin
          w_raw = MAX_DIM;
          h_raw = 2;
        end
        default: begin
          w_raw = pick_dim();
          h_raw = pick_dim();
        end
      endcase
      w_eff = (w_raw == 0) ? 1 : ((w_raw > MAX_DIM) ? MAX_DIM : w_raw);
      h_eff = (h_raw == 0) ? 1 : ((h_raw > MAX_DIM) ? MAX_DIM : h_raw);
      // keep large frames rare and thin
      if (w_eff * h_eff > 256) begin
        h_raw = $urandom_range(1, 4);
        h_eff = h_raw;
      end
      area = w_eff * h_eff;

      wait_results_done();
      if ($urandom_range(0, 1)) begin
        write_reg(REG_WIDTH, DIM_W'(w_raw));
        write_reg(REG_HEIGHT, DIM_W'(h_raw));
      end else begin
        write_reg(REG_HEIGHT, DIM_W'(h_raw));
        write_reg(REG_WIDTH, DIM_W'(w_raw));
      end

      burst   = ($urandom_range(0, 3) == 0);
      images  = $urandom_range(1, 2);
      dropped = 1'b0;
      for (int img = 0; img < images && !dropped; img++) begin
        loaded  = 0;
        fetched = 0;
        n_sent  = 0;
        cut_at  = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 2 * area - 1)
                                               : 2 * area + 1000;
        while (fetched < area && !dropped) begin
          if (n_sent == cut_at) begin
            dropped = 1'b1;
          end else begin
            // occasionally let every result drain before going on
            if ($urandom_range(0, 49) == 0) wait_results_done();
            noise = ($urandom_range(0, 19) == 0);
            // loading phase: load normally, stray fetch is noise;
            // fetching phase: the other way round
            if ((loaded < area) != noise) begin
              issue_req(REQ_LOAD, CHANNEL_BITS'($urandom()), CHANNEL_BITS'($urandom()),
                        CHANNEL_BITS'($urandom()));
              if (loaded < area) loaded++;
            end else begin
              issue_req(REQ_FETCH, CHANNEL_BITS'($urandom()), CHANNEL_BITS'($urandom()),
                        CHANNEL_BITS'($urandom()));
              if (loaded == area) fetched++;
            end
            n_sent++;
          end
        end
        // fetch on the freshly emptied store
        if (!dropped && $urandom_range(0, 2) == 0) begin
          issue_req(REQ_FETCH, CHANNEL_BITS'($urandom()), CHANNEL_BITS'($urandom()),
                    CHANNEL_BITS'($urandom()));
        end
      end
    end

    burst = 1'b0;
    wait_results_done();

    $display("Run covered %0d requests under %0d register writes.", n_items, n_configs);
    $display("%0d rotated frames fetched in full, %0d requests rejected as expected.",
             frames, rejects);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
